### design/aec_pkg.sv
`timescale 1ns / 1ps
// aec_pkg: shared types and constants for the antialias edge classifier
// no dependencies; imported by every module of the block

package aec_pkg;

	localparam int PIX_W = 8;
	localparam int ROW_W = 12;
	localparam int FW_W  = 11;
	localparam int TH_W  = 8;
	localparam int CFG_W = 12;
	localparam int IDX_W = 2;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST    = 11'd640;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST   = 12'd480;
	localparam logic [TH_W-1:0]  EDGE_THRESHOLD_RST = 8'd12;

	// edge class codes
	localparam logic [2:0] EC_NONE       = 3'd0;
	localparam logic [2:0] EC_TIP        = 3'd1;
	localparam logic [2:0] EC_BORDER     = 3'd2;
	localparam logic [2:0] EC_BORDER_TIP = 3'd3;
	localparam logic [2:0] EC_CORNER     = 3'd4;

	// false-edge class codes
	localparam logic [1:0] FC_NONE   = 2'd0;
	localparam logic [1:0] FC_TIP    = 2'd1;
	localparam logic [1:0] FC_BORDER = 2'd2;
	localparam logic [1:0] FC_CORNER = 2'd3;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH    = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MARK_NONE   = 2'd0,
		MARK_TIP    = 2'd1,
		MARK_BORDER = 2'd2
	} mark_t;

	// position of the pixel in the frame, decoded when it is accepted
	typedef struct packed {
		logic has_result; // row >= 1
		logic row_ge2;
		logic row_ge3;
		logic last_row;
		logic col_ge1;
		logic col_ge2;
		logic col_inner;  // 1 <= col <= width - 2
		logic col_last;
	} pos_flags_t;

	typedef struct packed {
		logic [2:0] edge_class;
		logic [1:0] false_edge_class;
	} class_t;

endpackage

### design/antialias_edge_classifier_top.sv
`timescale 1ns / 1ps
// antialias_edge_classifier_top: raster position tracking, read-modify-write
// stage and output register; uses aec_pkg, aec_line_store, aec_classify
//
// Usage:
//   Pixels enter in raster order on the in_valid/in_ready channel, one
//   8-bit gray value per transfer. Results leave on out_valid/out_ready.
//   Results lag one row: the pixel at row R >= 1, column c gives the
//   classes for (R-1, c); on the last row it also gives the result for
//   (R, c), and end_of_frame flags the frame's last result. Row 0 gives
//   no result. last_of_run marks the final result of each input transfer.
//   Timing: a pixel is accepted and its line memories are read on the same
//   edge; its first result then moves from the read-modify-write stage into
//   the output register. One pixel per cycle is sustained while out_ready
//   is high; on the last row each pixel gives two results through the
//   single output register. Entries are written back when the pixel
//   leaves the read-modify-write stage; a read on the same edge is forwarded.
//   When the receiver stalls, the result holds in the output register and
//   one more pixel is taken into the stage behind it, then in_ready drops.
//   Reset clears the row and column counters and restores the default
//   frame size and threshold; the line memories are not cleared and hold
//   no valid data until the first row of a frame has been written.
//   Configuration writes go through cfg_wr_en/cfg_index/cfg_wdata while idle.

module antialias_edge_classifier_top
	import aec_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  pixel_t           pixel,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       edge_class,
	output logic [1:0]       false_edge_class,
	output logic             last_of_run,
	output logic             end_of_frame
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = COL_W + 1;

	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	logic [TH_W-1:0]  edge_threshold_q;

	logic [WID_W-1:0] width_eff;
	logic [ROW_W-1:0] height_eff;
	logic [COL_W-1:0] col_q, col_cur;
	logic [ROW_W-1:0] row_q, row_cur;
	logic             col_is_last, row_is_last;
	pos_flags_t       flags_cur;

	logic             accept;
	logic             s1_valid_q, s1_phase_q;
	pixel_t           pixel_s1;
	logic [COL_W-1:0] col_s1;
	pos_flags_t       flags_s1;
	logic             out_load_ok, s1_emit, s1_done;

	pixel_t mid, right, up, left;
	class_t main_class, tail_class;

	logic       out_valid_q;
	class_t     class_q;
	logic       last_of_run_q, end_of_frame_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= FRAME_WIDTH_RST;
			frame_height_q   <= FRAME_HEIGHT_RST;
			edge_threshold_q <= EDGE_THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_wdata[FW_W-1:0];
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_wdata[ROW_W-1:0];
				REG_EDGE_THRESHOLD: edge_threshold_q <= cfg_wdata[TH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp frame size to the supported range
	always_comb begin
		if (32'(frame_width_q) > MAX_WIDTH) begin
			width_eff = WID_W'(MAX_WIDTH);
		end else if (frame_width_q < 11'd3) begin
			width_eff = WID_W'(3);
		end else begin
			width_eff = WID_W'(frame_width_q);
		end
		height_eff = (frame_height_q < 12'd3) ? 12'd3 : frame_height_q;
	end

	// current position, counters past a shrunk frame read as the last one
	always_comb begin
		col_cur = ({1'b0, col_q} < width_eff) ? col_q : COL_W'(width_eff - 1'b1);
		row_cur = (row_q < height_eff) ? row_q : (height_eff - 12'd1);
		col_is_last = ({1'b0, col_cur} == width_eff - 1'b1);
		row_is_last = (row_cur == height_eff - 12'd1);
		flags_cur.has_result = (row_cur != '0);
		flags_cur.row_ge2    = (row_cur >= 12'd2);
		flags_cur.row_ge3    = (row_cur >= 12'd3);
		flags_cur.last_row   = row_is_last;
		flags_cur.col_ge1    = (col_cur != '0);
		flags_cur.col_ge2    = (col_cur >= COL_W'(2));
		flags_cur.col_inner  = (col_cur != '0) && ({1'b0, col_cur} + WID_W'(2) <= width_eff);
		flags_cur.col_last   = col_is_last;
	end

	assign accept = in_valid && in_ready;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_is_last) begin
				col_q <= '0;
				row_q <= row_is_last ? '0 : (row_cur + 12'd1);
			end else begin
				col_q <= col_cur + 1'b1;
				row_q <= row_cur;
			end
		end
	end

	// stage 1 sequencing: no result on row 0, else one or two results, then write back
	assign out_load_ok = !out_valid_q || out_ready;
	assign s1_emit     = s1_valid_q && flags_s1.has_result && out_load_ok;
	assign s1_done     = s1_valid_q && (!flags_s1.has_result
		|| (out_load_ok && (!flags_s1.last_row || s1_phase_q)));
	assign in_ready    = !s1_valid_q || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_phase_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_done) begin
				s1_phase_q <= 1'b0;
			end else if (s1_emit && flags_s1.last_row) begin
				s1_phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			col_s1   <= col_cur;
			flags_s1 <= flags_cur;
		end
	end

	aec_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_store (
		.clk          (clk),
		.rd_en        (accept),
		.rd_col       (col_cur),
		.wr_en        (s1_done),
		.wr_col       (col_s1),
		.wr_above     (pixel_s1),
		.wr_two_above (mid),
		.mid          (mid),
		.right        (right),
		.up           (up),
		.left         (left)
	);

	aec_classify u_classify (
		.flags      (flags_s1),
		.threshold  (edge_threshold_q),
		.mc         (mid),
		.ml         (left),
		.mr         (right),
		.up         (up),
		.cur        (pixel_s1),
		.main_class (main_class),
		.tail_class (tail_class)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_ok) begin
			out_valid_q <= s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_emit) begin
			if (s1_phase_q) begin
				class_q        <= tail_class;
				last_of_run_q  <= 1'b1;
				end_of_frame_q <= flags_s1.col_last;
			end else begin
				class_q        <= main_class;
				last_of_run_q  <= !flags_s1.last_row;
				end_of_frame_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign edge_class       = class_q.edge_class;
	assign false_edge_class = class_q.false_edge_class;
	assign last_of_run      = last_of_run_q;
	assign end_of_frame     = end_of_frame_q;

endmodule

### design/aec_line_store.sv
`timescale 1ns / 1ps
// aec_line_store: the two line memories (previous row, row before that)
// with registered reads and same-edge write forwarding; uses aec_pkg

module aec_line_store
	import aec_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  pixel_t                       wr_above,
	input  pixel_t                       wr_two_above,
	output pixel_t                       mid,
	output pixel_t                       right,
	output pixel_t                       up,
	output pixel_t                       left
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	pixel_t mem_above [MAX_WIDTH];
	pixel_t mem_two_above [MAX_WIDTH];

	logic [COL_W-1:0] rd_right_col;
	logic [COL_W-1:0] rd_left_col;
	pixel_t mid_q, right_q, up_q, left_q;

	// neighbor addresses; the wrapped ones are never used by the classifier
	assign rd_right_col = rd_col + 1'b1;
	assign rd_left_col  = rd_col - 1'b1;

	// write back, and read with forwarding of a write on the same edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_above[wr_col]     <= wr_above;
			mem_two_above[wr_col] <= wr_two_above;
		end
		if (rd_en) begin
			mid_q   <= (wr_en && wr_col == rd_col) ? wr_above : mem_above[rd_col];
			right_q <= (wr_en && wr_col == rd_right_col) ? wr_above
				: mem_above[rd_right_col];
			up_q    <= (wr_en && wr_col == rd_col) ? wr_two_above : mem_two_above[rd_col];
			left_q  <= (wr_en && wr_col == rd_left_col) ? wr_two_above
				: mem_two_above[rd_left_col];
		end
	end

	assign mid   = mid_q;
	assign right = right_q;
	assign up    = up_q;
	assign left  = left_q;

endmodule

### design/aec_classify.sv
`timescale 1ns / 1ps
// aec_classify: threshold tests, border/tip marks and class encoding
// for one pixel of the row above and one of the last row; uses aec_pkg

module aec_classify
	import aec_pkg::*;
(
	input  pos_flags_t      flags,
	input  logic [TH_W-1:0] threshold,
	input  pixel_t          mc,
	input  pixel_t          ml,
	input  pixel_t          mr,
	input  pixel_t          up,
	input  pixel_t          cur,
	output class_t          main_class,
	output class_t          tail_class
);

	function automatic logic is_edge(pixel_t s, pixel_t o, logic [TH_W-1:0] th);
		pixel_t d;
		d = (s > o) ? (s - o) : (o - s);
		return d > th;
	endfunction

	// darker pixel of the pair is border
	function automatic mark_t pair_mark(pixel_t s, pixel_t o);
		return (s < o) ? MARK_BORDER : MARK_TIP;
	endfunction

	function automatic mark_t axis_mark(pixel_t s, pixel_t b, pixel_t a, logic after_en,
		logic before_en, logic [TH_W-1:0] th);
		mark_t m;
		if (after_en && is_edge(s, a, th)) begin
			m = pair_mark(s, a);
		end else if (before_en && is_edge(s, b, th)) begin
			m = pair_mark(s, b);
		end else begin
			m = MARK_NONE;
		end
		return m;
	endfunction

	function automatic class_t encode(mark_t dx, mark_t dy);
		logic [1:0] borders;
		logic [1:0] tips;
		class_t     c;
		borders = 2'((dx == MARK_BORDER)) + 2'((dy == MARK_BORDER));
		tips    = 2'((dx == MARK_TIP)) + 2'((dy == MARK_TIP));
		if (borders == 2'd2) begin
			c.edge_class = EC_CORNER;
		end else if (borders == 2'd1) begin
			c.edge_class = (tips != 2'd0) ? EC_BORDER_TIP : EC_BORDER;
		end else begin
			c.edge_class = (tips != 2'd0) ? EC_TIP : EC_NONE;
		end
		if (tips == 2'd2) begin
			c.false_edge_class = FC_CORNER;
		end else if (borders != 2'd0) begin
			c.false_edge_class = FC_TIP;
		end else if (tips != 2'd0) begin
			c.false_edge_class = FC_BORDER;
		end else begin
			c.false_edge_class = FC_NONE;
		end
		return c;
	endfunction

	mark_t dx, dy, dy_tail;

	// horizontal mark on interior rows, vertical on interior columns
	always_comb begin
		dx = flags.row_ge2
			? axis_mark(mc, ml, mr, flags.col_inner, flags.col_ge2, threshold) : MARK_NONE;
		dy = flags.col_inner
			? axis_mark(mc, up, cur, flags.row_ge2, flags.row_ge3, threshold) : MARK_NONE;
		// last row pixel only has its upper neighbor
		dy_tail = (flags.col_inner && is_edge(cur, mc, threshold))
			? pair_mark(cur, mc) : MARK_NONE;
	end

	assign main_class = encode(dx, dy);
	assign tail_class = encode(MARK_NONE, dy_tail);

endmodule

### design/aec_checker.sv
`timescale 1ns / 1ps
// aec_checker: port-level checks on the result channel of the classifier
// uses aec_pkg; bound to antialias_edge_classifier_top below

module aec_checker
	import aec_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] edge_class,
	input logic [1:0] false_edge_class,
	input logic       last_of_run,
	input logic       end_of_frame
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(edge_class)
			&& $stable(false_edge_class) && $stable(last_of_run) && $stable(end_of_frame))
		else $error("result changed while stalled");

	// edge class codes run from EC_NONE up to EC_CORNER, and no higher
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> edge_class <= EC_CORNER)
		else $error("edge class out of range");

	// frame end is the tail result of a last row pixel: vertical mark only
	a_eof_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> last_of_run && edge_class != EC_BORDER_TIP
			&& edge_class != EC_CORNER)
		else $error("frame end on a result that is not a last row tail");

	// two tips give tip edge class
	a_two_tips: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && false_edge_class == FC_CORNER |-> edge_class == EC_TIP)
		else $error("false corner without tip edge class");

endmodule

bind antialias_edge_classifier_top aec_checker u_aec_checker (.*);
